/* hdl/arp_pkg.sv */
`default_nettype none

package arp_pkg;

  // Default cache depth
  localparam int CACHE_ENTRIES_DEF = 16;

  // Field widths
  localparam int IP_W       = 32;
  localparam int MAC_W      = 48;
  localparam int OP_W       = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_HIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MISS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPLY = 2'd2;

  // ARP opcodes (host order)
  localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;
  localparam logic [OP_W-1:0] OP_REPLY   = 16'd2;

  // Item actions
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_PACKET = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b1;

  // Input item
  typedef struct packed {
    logic             action;
    logic [IP_W-1:0]  query_ip;
    logic [OP_W-1:0]  arp_opcode;
    logic [IP_W-1:0]  sender_ip;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  target_ip;
  } arp_in_t;

  // Result item
  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [MAC_W-1:0]  result_mac;
    logic [IP_W-1:0]   result_ip;
  } arp_out_t;

endpackage

`default_nettype wire

/* hdl/arp_cache_mem.sv */
`default_nettype none

// IP/MAC entry storage: one write port, one read port with registered data
module arp_cache_mem #(
  parameter int ENTRIES = arp_pkg::CACHE_ENTRIES_DEF,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [IDX_W-1:0]           wr_addr,
  input  wire logic [arp_pkg::IP_W-1:0]   wr_ip,
  input  wire logic [arp_pkg::MAC_W-1:0]  wr_mac,
  input  wire logic                       rd_en,
  input  wire logic [IDX_W-1:0]           rd_addr,
  output      logic [arp_pkg::IP_W-1:0]   rd_ip,
  output      logic [arp_pkg::MAC_W-1:0]  rd_mac
);

  logic [arp_pkg::IP_W-1:0]  ip_mem  [ENTRIES];
  logic [arp_pkg::MAC_W-1:0] mac_mem [ENTRIES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[wr_addr]  <= wr_ip;
      mac_mem[wr_addr] <= wr_mac;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ip  <= ip_mem[rd_addr];
      rd_mac <= mac_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/arp_cache_and_responder.sv */
// Lookup: entries are read and compared one per cycle on one comparator, from
//   entry 0 on; a hit ends the scan at that entry, a miss after the last entry.
// ARP request for own IP: result goes through S_EMIT to the output register. ARP
//   reply: sender IP/MAC stored at the write pointer, no result. Input stalled
//   while a lookup scan or a pending result is in work, held longer by out_stall.
// Reset (rst_n low, synchronous) clears valid bits, write pointer, own IP/MAC.
`default_nettype none

module arp_cache_and_responder #(
  parameter int CACHE_ENTRIES = arp_pkg::CACHE_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire arp_pkg::arp_in_t               in_data,
  // result channel
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      arp_pkg::arp_out_t              out_data,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [arp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  // control registers
  state_t                       state_r, state_nxt;
  logic [IDX_W-1:0]             scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic                         pend_r, pend_nxt;
  logic [CACHE_ENTRIES-1:0]     valid_r, valid_nxt;
  logic [IDX_W-1:0]             wp_r, wp_nxt;
  logic [arp_pkg::IP_W-1:0]     own_ip_r, own_ip_nxt;
  logic [arp_pkg::MAC_W-1:0]    own_mac_r, own_mac_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // payload registers
  logic [arp_pkg::IP_W-1:0]     qip_r, qip_nxt;
  arp_pkg::arp_out_t            res_r, res_nxt;
  arp_pkg::arp_out_t            out_data_r;

  // datapath
  logic                         in_xfer;
  logic                         out_free;
  logic                         out_load;
  logic                         ip_eq;
  logic                         hit;
  logic                         mem_wr_en;
  logic                         mem_rd_en;
  logic [arp_pkg::IP_W-1:0]     rd_ip;
  logic [arp_pkg::MAC_W-1:0]    rd_mac;

  arp_cache_mem #(
    .ENTRIES (CACHE_ENTRIES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wp_r),
    .wr_ip   (in_data.sender_ip),
    .wr_mac  (in_data.sender_mac),
    .rd_en   (mem_rd_en),
    .rd_addr (scan_idx_r),
    .rd_ip   (rd_ip),
    .rd_mac  (rd_mac)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared compare: cache entry vs. query, or own IP vs. request target
  assign ip_eq = (state_r == S_SCAN) ? (rd_ip == qip_r) : (in_data.target_ip == own_ip_r);
  assign hit   = pend_r && valid_r[cmp_idx_r] && ip_eq;

  assign mem_wr_en = in_xfer && (in_data.action == arp_pkg::ACT_PACKET) &&
                     (in_data.arp_opcode == arp_pkg::OP_REPLY);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    pend_nxt      = pend_r;
    valid_nxt     = valid_r;
    wp_nxt        = wp_r;
    qip_nxt       = qip_r;
    res_nxt       = res_r;
    mem_rd_en     = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.action == arp_pkg::ACT_LOOKUP) begin
            qip_nxt      = in_data.query_ip;
            scan_idx_nxt = '0;
            pend_nxt     = 1'b0;
            state_nxt    = S_SCAN;
          end else if (in_data.arp_opcode == arp_pkg::OP_REPLY) begin
            valid_nxt[wp_r] = 1'b1;
            wp_nxt          = (wp_r == LAST_IDX) ? '0 : wp_r + IDX_ONE;
          end else if (in_data.arp_opcode == arp_pkg::OP_REQUEST && ip_eq) begin
            res_nxt.result_kind = arp_pkg::KIND_REPLY;
            res_nxt.result_mac  = in_data.sender_mac;
            res_nxt.result_ip   = in_data.sender_ip;
            state_nxt           = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        // issue next read while comparing the previous one
        mem_rd_en    = 1'b1;
        scan_idx_nxt = (scan_idx_r == LAST_IDX) ? '0 : scan_idx_r + IDX_ONE;
        cmp_idx_nxt  = scan_idx_r;
        pend_nxt     = 1'b1;
        if (hit) begin
          res_nxt.result_kind = arp_pkg::KIND_HIT;
          res_nxt.result_mac  = rd_mac;
          res_nxt.result_ip   = qip_r;
          state_nxt           = S_EMIT;
        end else if (pend_r && cmp_idx_r == LAST_IDX) begin
          res_nxt.result_kind = arp_pkg::KIND_MISS;
          res_nxt.result_mac  = '0;
          res_nxt.result_ip   = qip_r;
          state_nxt           = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration writes
  always_comb begin
    own_ip_nxt  = own_ip_r;
    own_mac_nxt = own_mac_r;
    if (cfg_we) begin
      case (cfg_index)
        arp_pkg::REG_OWN_IP:  own_ip_nxt  = cfg_wdata[arp_pkg::IP_W-1:0];
        arp_pkg::REG_OWN_MAC: own_mac_nxt = cfg_wdata[arp_pkg::MAC_W-1:0];
        default: ;
      endcase
    end
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_idx_r  <= '0;
      cmp_idx_r   <= '0;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      wp_r        <= '0;
      own_ip_r    <= '0;
      own_mac_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      wp_r        <= wp_nxt;
      own_ip_r    <= own_ip_nxt;
      own_mac_r   <= own_mac_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    qip_r <= qip_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

endmodule

`default_nettype wire

/* hdl/arp_chk.sv */
`default_nettype none

module arp_chk (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire arp_pkg::arp_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire arp_pkg::arp_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a lookup transfer always starts a multi-cycle scan
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.action == arp_pkg::ACT_LOOKUP) |=> in_stall)
    else $error("input not stalled after lookup transfer");

  // no unused result kind
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.result_kind == arp_pkg::KIND_HIT) ||
                  (out_data.result_kind == arp_pkg::KIND_MISS) ||
                  (out_data.result_kind == arp_pkg::KIND_REPLY))
    else $error("bad result kind");

  // a miss carries a zero MAC
  a_miss_mac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == arp_pkg::KIND_MISS) |-> out_data.result_mac == '0)
    else $error("miss with nonzero MAC");

  // reset empties the result stage
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind arp_cache_and_responder arp_chk u_arp_chk (.*);

`default_nettype wire
